// File: rtl/core/uffc_pkg.sv
// Package with the shared types, constants and helpers of the UART FIFO block.
package uffc_pkg;

  // Ring depth of each FIFO; one slot always stays free.
  localparam int DEPTH = 64;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = PTR_W + 1;
  localparam int HW_W = 6;
  localparam int REPORT_W = 6;
  localparam logic [HW_W-1:0] RTS_MARK_RESET = HW_W'(48);

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [FILL_W-1:0] fill_t;

  // Operation codes of one item.
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_RX    = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  data_in;
  } cmd_t;

  typedef struct packed {
    logic [7:0]          data_out;
    logic                data_valid;
    logic                accepted;
    logic                rts_n;
    logic                overflow;
    logic                tx_armed;
    logic [REPORT_W-1:0] rx_fill;
    logic [REPORT_W-1:0] tx_fill;
  } result_t;

  // Pointer advance with wrap at the ring depth.
  function automatic ptr_t next_pos(input ptr_t p);
    ptr_t r;
    if (p == ptr_t'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + ptr_t'(1);
    end
    return r;
  endfunction

  // Number of bytes held between read and write pointers.
  function automatic fill_t fill_of(input ptr_t rd, input ptr_t wr);
    fill_t r;
    if (wr >= rd) begin
      r = fill_t'(wr) - fill_t'(rd);
    end else begin
      r = fill_t'(wr) + fill_t'(DEPTH) - fill_t'(rd);
    end
    return r;
  endfunction

  // Fill level as reported on the result, masked to the report width.
  function automatic logic [REPORT_W-1:0] fill_report(input fill_t f);
    logic [FILL_W+REPORT_W-1:0] ext;
    ext = {{REPORT_W{1'b0}}, f};
    return ext[REPORT_W-1:0];
  endfunction

  // True when the fill level lies above the high-water mark.
  function automatic logic above_mark(input fill_t f, input logic [HW_W-1:0] hw);
    logic [FILL_W+HW_W-1:0] fe;
    logic [FILL_W+HW_W-1:0] he;
    fe = {{HW_W{1'b0}}, f};
    he = {{FILL_W{1'b0}}, hw};
    return fe > he;
  endfunction

endpackage

// File: rtl/core/uart_fifo_rts_flow_control_unit.sv
// Top level of the UART transmit and receive FIFO block with RTS flow control.
//
// One item is an event on the cmd port: a host write, a host read, a byte
// received from the line, or a transmitter-ready tick. An item is taken at a
// rising clock edge where start is high and busy is low. busy stays low, so
// a new item may be given in every cycle.
// Each item gives exactly one result on the result port, marked by strobe
// for one cycle, in the cycle after the item was taken. The byte stores are
// synchronous memories read at the edge that takes the item, and their read
// data feeds the result in the following cycle. Throughput is one item per cycle.
// The receiver cannot hold results off; strobe is not repeated.
// The high-water mark is written through cfg_we and cfg_wdata; the user must
// do so only while no item is in flight, as the block does not enforce it.
// Synchronous reset empties both FIFOs, clears the armed, rts and overflow
// flags, and sets the high-water mark to 48. The byte stores are not
// cleared: an entry is only read after it has been written.
module uart_fifo_rts_flow_control_unit (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  uffc_pkg::cmd_t         cmd,
  output logic                   strobe,
  output uffc_pkg::result_t      result,
  input  logic                   cfg_we,
  input  logic [uffc_pkg::HW_W-1:0] cfg_wdata
);
  import uffc_pkg::*;

  // Control state.
  ptr_t tx_rd, tx_rd_next, tx_wr, tx_wr_next;
  ptr_t rx_rd, rx_rd_next, rx_wr, rx_wr_next;
  logic armed, armed_next;
  logic rts, rts_next;
  logic ovf, ovf_next;
  logic [HW_W-1:0] rts_mark;

  // Byte stores and their registered read data.
  logic [7:0] tx_store [DEPTH];
  logic [7:0] rx_store [DEPTH];
  logic [7:0] tx_rdata, rx_rdata;
  logic tx_we, rx_we;

  // Result registers.
  logic res_valid, res_valid_next;
  logic res_acc, res_acc_next;
  logic res_from_tx;
  logic [REPORT_W-1:0] res_rx_fill, res_tx_fill;

  logic accept;
  fill_t rx_fill_new;

  assign busy = 1'b0;
  assign accept = start && !busy;

  // Per-item decode of pushes, pops and flag updates.
  always_comb begin
    tx_rd_next = tx_rd;
    tx_wr_next = tx_wr;
    rx_rd_next = rx_rd;
    rx_wr_next = rx_wr;
    armed_next = armed;
    rts_next = rts;
    ovf_next = ovf;
    tx_we = 1'b0;
    rx_we = 1'b0;
    res_valid_next = 1'b0;
    res_acc_next = 1'b0;
    rx_fill_new = '0;
    if (accept) begin
      unique case (cmd.op)
        OP_WRITE: begin
          if (next_pos(tx_wr) != tx_rd) begin
            tx_we = 1'b1;
            tx_wr_next = next_pos(tx_wr);
            res_acc_next = 1'b1;
          end
          armed_next = 1'b1;
        end
        OP_READ: begin
          if (rx_rd != rx_wr) begin
            rx_rd_next = next_pos(rx_rd);
            res_valid_next = 1'b1;
          end
          rx_fill_new = fill_of(rx_rd_next, rx_wr);
          if (!above_mark(rx_fill_new, rts_mark)) begin
            rts_next = 1'b0;
          end
        end
        OP_RX: begin
          if (next_pos(rx_wr) != rx_rd) begin
            rx_we = 1'b1;
            rx_wr_next = next_pos(rx_wr);
            res_acc_next = 1'b1;
          end else begin
            ovf_next = 1'b1;
          end
          rx_fill_new = fill_of(rx_rd, rx_wr_next);
          if (above_mark(rx_fill_new, rts_mark)) begin
            rts_next = 1'b1;
          end
        end
        OP_TICK: begin
          if (armed) begin
            if (tx_rd != tx_wr) begin
              tx_rd_next = next_pos(tx_rd);
              res_valid_next = 1'b1;
            end else begin
              armed_next = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Pointer, flag and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_rd <= '0;
      tx_wr <= '0;
      rx_rd <= '0;
      rx_wr <= '0;
      armed <= 1'b0;
      rts <= 1'b0;
      ovf <= 1'b0;
      rts_mark <= RTS_MARK_RESET;
      strobe <= 1'b0;
    end else begin
      tx_rd <= tx_rd_next;
      tx_wr <= tx_wr_next;
      rx_rd <= rx_rd_next;
      rx_wr <= rx_wr_next;
      armed <= armed_next;
      rts <= rts_next;
      ovf <= ovf_next;
      strobe <= accept;
      if (cfg_we) begin
        rts_mark <= cfg_wdata;
      end
    end
  end

  // Transmit store: one write and one read port.
  always_ff @(posedge clk) begin
    if (tx_we) begin
      tx_store[tx_wr] <= cmd.data_in;
    end
    tx_rdata <= tx_store[tx_rd];
  end

  // Receive store: one write and one read port.
  always_ff @(posedge clk) begin
    if (rx_we) begin
      rx_store[rx_wr] <= cmd.data_in;
    end
    rx_rdata <= rx_store[rx_rd];
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    res_valid <= res_valid_next;
    res_acc <= res_acc_next;
    res_from_tx <= (cmd.op == OP_TICK);
    res_rx_fill <= fill_report(fill_of(rx_rd_next, rx_wr_next));
    res_tx_fill <= fill_report(fill_of(tx_rd_next, tx_wr_next));
  end

  // Result assembly; the flags are the state left by the item.
  always_comb begin
    if (!res_valid) begin
      result.data_out = 8'h00;
    end else if (res_from_tx) begin
      result.data_out = tx_rdata;
    end else begin
      result.data_out = rx_rdata;
    end
    result.data_valid = res_valid;
    result.accepted = res_acc;
    result.rts_n = rts;
    result.overflow = ovf;
    result.tx_armed = armed;
    result.rx_fill = res_rx_fill;
    result.tx_fill = res_tx_fill;
  end

endmodule
